[sv/gcdff_pkg.sv]
// ----------------------------------------------------------------------------
// gcdff_pkg
// Shared types and constants of the gravity-compensation direction and
// feed-forward unit: register indexes, mode codes, filter constants, and the
// configuration and queue entry structs.
// ----------------------------------------------------------------------------
`default_nettype none

package gcdff_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SHOULDER_THR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ELBOW_THR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_ELEV     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_SQUARE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_LINEAR = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_OFFSET = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ELBOW_PRESS  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SYNERGY_MODE = 3'd7;

  // synergy modes; the fourth code means off
  localparam logic [1:0] MODE_OFF  = 2'd0;
  localparam logic [1:0] MODE_EXT  = 2'd1;
  localparam logic [1:0] MODE_FLEX = 2'd2;

  localparam int SHOULDER_ALPHA_Q8      = 26;
  localparam int ELBOW_ALPHA_Q8         = 26;
  localparam int SHOULDER_PERSIST_LIMIT = 15;
  localparam int ELBOW_PERSIST_LIMIT    = 15;
  localparam int PERSIST_W              = 5;
  localparam int TREND_W                = 24;

  localparam logic [15:0] ELBOW_PRESSURE_RST = 16'd2560;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic        [14:0] shoulder_dir_threshold;
    logic        [14:0] elbow_dir_threshold;
    logic signed [15:0] min_elevation;
    logic signed [31:0] coeff_square;
    logic signed [31:0] coeff_linear;
    logic signed [31:0] coeff_offset;
    logic        [15:0] elbow_pressure;
    logic        [1:0]  synergy_mode;
  } gcdff_cfg_t;

  // one classified sample, handed from the front to the back
  typedef struct packed {
    logic signed [15:0] elevation;
    logic               ff_enable;
    logic               lift;
    logic               elbow_latch;
  } gcdff_entry_t;

endpackage

`default_nettype wire

[sv/gcdff_in_if.sv]
// ----------------------------------------------------------------------------
// gcdff_in_if
// Sample channel: valid/ready request carrying shoulder elevation and elbow
// angle.
// ----------------------------------------------------------------------------
`default_nettype none

interface gcdff_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] elevation;
  logic signed [15:0] elbow_angle;

  modport source (output valid, output elevation, output elbow_angle, input ready);
  modport sink   (input valid, input elevation, input elbow_angle, output ready);
endinterface

`default_nettype wire

[sv/gcdff_out_if.sv]
// ----------------------------------------------------------------------------
// gcdff_out_if
// Result channel: valid/ready request carrying the pressure references and
// the two status flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface gcdff_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] shoulder_pressure_ref;
  logic [15:0] elbow_pressure_ref;
  logic        lift_active;
  logic        elbow_engaged;

  modport source (output valid, output shoulder_pressure_ref, output elbow_pressure_ref,
                  output lift_active, output elbow_engaged, input ready);
  modport sink   (input valid, input shoulder_pressure_ref, input elbow_pressure_ref,
                  input lift_active, input elbow_engaged, output ready);
endinterface

`default_nettype wire

[sv/gcdff_front.sv]
// ----------------------------------------------------------------------------
// gcdff_front
// Accept a sample, update the shoulder detector and, with synergy on, the elbow
// detector, and classify the sample for the feed-forward back end.
// ----------------------------------------------------------------------------
`default_nettype none

module gcdff_front (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire gcdff_pkg::gcdff_cfg_t  cfg,
  gcdff_in_if.sink                    in_ch,
  output logic                        push_valid,
  input  wire logic                   push_ready,
  output gcdff_pkg::gcdff_entry_t     push_data
);

  localparam int TW = gcdff_pkg::TREND_W;
  localparam int PW = gcdff_pkg::PERSIST_W;

  // trend' = floor((a*diff*128 + (256-a)*trend + 128) / 256)
  function automatic logic signed [TW-1:0] smooth(input logic signed [TW-1:0] trend,
                                                  input logic signed [16:0]   diff,
                                                  input int                   alpha);
    logic signed [35:0] a_s;
    logic signed [35:0] num;
    a_s = 36'(alpha);
    num = a_s * 36'(diff) * 36'sd128 + (36'sd256 - a_s) * 36'(trend) + 36'sd128;
    return num[TW+7:8];
  endfunction

  function automatic logic [TW-1:0] magnitude(input logic signed [TW-1:0] v);
    return v[TW-1] ? TW'(-v) : TW'(v);
  endfunction

  logic                 busy_r;
  logic signed [15:0]   elev_r;
  logic signed [15:0]   elbow_r;

  logic signed [15:0]   last_elev_r, last_elev_nxt;
  logic signed [TW-1:0] sh_trend_r, sh_trend_nxt;
  logic [PW-1:0]        sh_persist_r, sh_persist_nxt;
  logic                 lift_r, lift_nxt;
  logic signed [15:0]   last_elbow_r, last_elbow_nxt;
  logic signed [TW-1:0] el_trend_r, el_trend_nxt;
  logic [PW-1:0]        el_persist_r, el_persist_nxt;
  logic                 el_latch_r, el_latch_nxt;

  logic                 fire;
  logic                 synergy_on;
  logic signed [TW-1:0] sh_trend_new;
  logic signed [TW-1:0] el_trend_new;

  assign in_ch.ready = !busy_r;
  assign push_valid  = busy_r;
  assign fire        = busy_r && push_ready;
  assign synergy_on  = (cfg.synergy_mode == gcdff_pkg::MODE_EXT) ||
                       (cfg.synergy_mode == gcdff_pkg::MODE_FLEX);

  always_comb begin
    sh_trend_new = smooth(sh_trend_r, 17'(elev_r) - 17'(last_elev_r),
                          gcdff_pkg::SHOULDER_ALPHA_Q8);
    el_trend_new = smooth(el_trend_r, 17'(elbow_r) - 17'(last_elbow_r),
                          gcdff_pkg::ELBOW_ALPHA_Q8);

    sh_trend_nxt   = sh_trend_new;
    last_elev_nxt  = elev_r;
    sh_persist_nxt = sh_persist_r;
    lift_nxt       = lift_r;
    if (magnitude(sh_trend_new) > {2'b00, cfg.shoulder_dir_threshold, 7'd0}) begin
      if (sh_persist_r < PW'(gcdff_pkg::SHOULDER_PERSIST_LIMIT)) begin
        sh_persist_nxt = sh_persist_r + PW'(1);
      end else begin
        lift_nxt = !sh_trend_new[TW-1] && (sh_trend_new != '0);
      end
    end else begin
      sh_persist_nxt = '0;
    end

    el_trend_nxt   = el_trend_r;
    last_elbow_nxt = last_elbow_r;
    el_persist_nxt = el_persist_r;
    el_latch_nxt   = el_latch_r;
    if (synergy_on) begin
      el_trend_nxt   = el_trend_new;
      last_elbow_nxt = elbow_r;
      if (!el_latch_r) begin
        if (magnitude(el_trend_new) > {2'b00, cfg.elbow_dir_threshold, 7'd0}) begin
          if (el_persist_r < PW'(gcdff_pkg::ELBOW_PERSIST_LIMIT)) begin
            el_persist_nxt = el_persist_r + PW'(1);
          end else if ((cfg.synergy_mode == gcdff_pkg::MODE_EXT && el_trend_new[TW-1]) ||
                       (cfg.synergy_mode == gcdff_pkg::MODE_FLEX && !el_trend_new[TW-1] &&
                        el_trend_new != '0)) begin
            el_latch_nxt = 1'b1;
          end
        end else begin
          el_persist_nxt = '0;
        end
      end
    end

    push_data.elevation   = elev_r;
    push_data.ff_enable   = lift_nxt && (elev_r > cfg.min_elevation);
    push_data.lift        = lift_nxt;
    push_data.elbow_latch = el_latch_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      last_elev_r  <= '0;
      sh_trend_r   <= '0;
      sh_persist_r <= '0;
      lift_r       <= 1'b0;
      last_elbow_r <= '0;
      el_trend_r   <= '0;
      el_persist_r <= '0;
      el_latch_r   <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        busy_r <= 1'b1;
      end else if (fire) begin
        busy_r <= 1'b0;
      end
      if (fire) begin
        last_elev_r  <= last_elev_nxt;
        sh_trend_r   <= sh_trend_nxt;
        sh_persist_r <= sh_persist_nxt;
        lift_r       <= lift_nxt;
        last_elbow_r <= last_elbow_nxt;
        el_trend_r   <= el_trend_nxt;
        el_persist_r <= el_persist_nxt;
        el_latch_r   <= el_latch_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      elev_r  <= in_ch.elevation;
      elbow_r <= in_ch.elbow_angle;
    end
  end

`ifndef SYNTHESIS
  a_latch_holds: assert property (@(posedge clk) disable iff (!rst_n)
    el_latch_r |=> el_latch_r)
    else $error("elbow latch dropped without reset");
  a_lift_only_on_push: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(lift_r))
    else $error("lift flag changed without a sample");
  a_persist_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sh_persist_r <= PW'(gcdff_pkg::SHOULDER_PERSIST_LIMIT) &&
    el_persist_r <= PW'(gcdff_pkg::ELBOW_PERSIST_LIMIT))
    else $error("persistence counter beyond limit");
  a_push_frees: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> !busy_r)
    else $error("front stayed busy after push");
`endif

endmodule

`default_nettype wire

[sv/gcdff_queue.sv]
// ----------------------------------------------------------------------------
// gcdff_queue
// Short FIFO of classified samples between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module gcdff_queue (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    push_valid,
  output logic                         push_ready,
  input  wire gcdff_pkg::gcdff_entry_t push_data,
  output logic                         pop_valid,
  input  wire logic                    pop_ready,
  output gcdff_pkg::gcdff_entry_t      pop_data
);

  localparam int DEPTH = gcdff_pkg::QUEUE_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  gcdff_pkg::gcdff_entry_t slot_r [DEPTH];
  logic [AW-1:0] wptr_r, rptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + AW'(1);
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count beyond depth");
  a_full_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == CW'(DEPTH)) && !do_pop |=> count_r == CW'(DEPTH))
    else $error("full queue changed without a pop");
  a_empty_stays: assert property (@(posedge clk) disable iff (!rst_n)
    !pop_valid && !push_valid |=> !pop_valid)
    else $error("empty queue produced an entry");
`endif

endmodule

`default_nettype wire

[sv/gcdff_back.sv]
// ----------------------------------------------------------------------------
// gcdff_back
// Evaluate the quadratic feed-forward over a short multiply sequence, round,
// saturate and hold the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gcdff_back (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire gcdff_pkg::gcdff_cfg_t   cfg,
  input  wire logic                    pop_valid,
  output logic                         pop_ready,
  input  wire gcdff_pkg::gcdff_entry_t pop_data,
  gcdff_out_if.source                  out_ch
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL1 = 2'd1;
  localparam logic [1:0] ST_MUL2 = 2'd2;
  localparam logic [1:0] ST_SUM  = 2'd3;

  localparam logic signed [48:0] ROUND_HALF = 49'sd8388608;

  logic [1:0]          state_r;
  logic signed [15:0]  elev_r;
  logic                ff_r, lift_r, latch_r;
  logic signed [31:0]  sq_r;
  logic signed [47:0]  lin_r;
  logic signed [63:0]  quad_r;
  logic signed [48:0]  lo_r;

  logic                out_valid_r;
  logic [15:0]         sp_r, ep_r;
  logic                lift_out_r, eng_out_r;

  logic                out_free;
  logic                take;
  logic signed [63:0]  acc;
  logic signed [39:0]  pval;
  logic [15:0]         sp_val;

  assign pop_ready = (state_r == ST_IDLE);
  assign take      = pop_valid && pop_ready;
  assign out_free  = !out_valid_r || out_ch.ready;

  always_comb begin
    acc  = quad_r + 64'(lo_r);
    pval = acc[63:24];
    priority if (!ff_r) begin
      sp_val = '0;
    end else if (pval < 40'sd0) begin
      sp_val = '0;
    end else if (pval > 40'sd65535) begin
      sp_val = 16'hFFFF;
    end else begin
      sp_val = pval[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (take) state_r <= ST_MUL1;
        end
        ST_MUL1: state_r <= ST_MUL2;
        ST_MUL2: state_r <= ST_SUM;
        ST_SUM: begin
          if (out_free) state_r <= ST_IDLE;
        end
      endcase
      if (state_r == ST_SUM && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      elev_r  <= pop_data.elevation;
      ff_r    <= pop_data.ff_enable;
      lift_r  <= pop_data.lift;
      latch_r <= pop_data.elbow_latch;
    end
    if (state_r == ST_MUL1) begin
      sq_r  <= 32'(elev_r) * 32'(elev_r);
      lin_r <= 48'(cfg.coeff_linear) * 48'(elev_r);
    end
    if (state_r == ST_MUL2) begin
      quad_r <= 64'(cfg.coeff_square) * 64'(sq_r);
      lo_r   <= 49'(lin_r) + 49'(cfg.coeff_offset) + ROUND_HALF;
    end
    if (state_r == ST_SUM && out_free) begin
      sp_r       <= sp_val;
      ep_r       <= latch_r ? cfg.elbow_pressure : 16'd0;
      lift_out_r <= lift_r;
      eng_out_r  <= latch_r;
    end
  end

  assign out_ch.valid                 = out_valid_r;
  assign out_ch.shoulder_pressure_ref = sp_r;
  assign out_ch.elbow_pressure_ref    = ep_r;
  assign out_ch.lift_active           = lift_out_r;
  assign out_ch.elbow_engaged         = eng_out_r;

`ifndef SYNTHESIS
  a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> state_r == ST_MUL1)
    else $error("pop did not start the multiply sequence");
  a_sum_waits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SUM && !out_free |=> state_r == ST_SUM && out_valid_r)
    else $error("result lost while output stalled");
  a_no_lift_zero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SUM && out_free && !lift_r |=> out_ch.shoulder_pressure_ref == 16'd0)
    else $error("shoulder pressure while not lifting");
`endif

endmodule

`default_nettype wire

[sv/gravity_comp_direction_feedforward_unit.sv]
// ----------------------------------------------------------------------------
// gravity_comp_direction_feedforward_unit
// Shoulder lift detection with quadratic gravity feed-forward pressure and
// an elbow synergy detector that latches a fixed elbow pressure.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake         payload
//  -------   ---  ----------------  ------------------------------------------
//  in_ch     in   valid/ready       elevation 16s, elbow_angle 16s
//  out_ch    out  valid/ready       shoulder_pressure_ref 16u,
//                                   elbow_pressure_ref 16u, lift_active,
//                                   elbow_engaged
//  cfg_*     in   write enable      cfg_index 3b, cfg_data 32b, no read-back
//
//  Each request passes through the front (capture, then detector update and
//  classify) and the back (pop, two multiply steps, add/round/saturate); the
//  back takes no new entry until the last one is through its sequence, so its
//  multiply sequence sets the rate. Reset is synchronous and clears all
//  detector state directly; no clearing pass. A stalled output holds the back
//  in its final step while the two-entry queue keeps the front taking new
//  samples.
//
// ----------------------------------------------------------------------------
`default_nettype none

module gravity_comp_direction_feedforward_unit (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  gcdff_in_if.sink                              in_ch,
  gcdff_out_if.source                           out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [gcdff_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [gcdff_pkg::CFG_DATA_W-1:0] cfg_data
);

  gcdff_pkg::gcdff_cfg_t   cfg_r;

  logic                    push_valid, push_ready;
  gcdff_pkg::gcdff_entry_t push_data;
  logic                    pop_valid, pop_ready;
  gcdff_pkg::gcdff_entry_t pop_data;

  // register file: take each write into its field, truncate the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.shoulder_dir_threshold <= '0;
      cfg_r.elbow_dir_threshold    <= '0;
      cfg_r.min_elevation          <= '0;
      cfg_r.coeff_square           <= '0;
      cfg_r.coeff_linear           <= '0;
      cfg_r.coeff_offset           <= '0;
      cfg_r.elbow_pressure         <= gcdff_pkg::ELBOW_PRESSURE_RST;
      cfg_r.synergy_mode           <= gcdff_pkg::MODE_OFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gcdff_pkg::REG_SHOULDER_THR: cfg_r.shoulder_dir_threshold <= cfg_data[14:0];
        gcdff_pkg::REG_ELBOW_THR:    cfg_r.elbow_dir_threshold    <= cfg_data[14:0];
        gcdff_pkg::REG_MIN_ELEV:     cfg_r.min_elevation          <= cfg_data[15:0];
        gcdff_pkg::REG_COEFF_SQUARE: cfg_r.coeff_square           <= cfg_data[31:0];
        gcdff_pkg::REG_COEFF_LINEAR: cfg_r.coeff_linear           <= cfg_data[31:0];
        gcdff_pkg::REG_COEFF_OFFSET: cfg_r.coeff_offset           <= cfg_data[31:0];
        gcdff_pkg::REG_ELBOW_PRESS:  cfg_r.elbow_pressure         <= cfg_data[15:0];
        gcdff_pkg::REG_SYNERGY_MODE: cfg_r.synergy_mode           <= cfg_data[1:0];
      endcase
    end
  end

  // front: accept, run the shoulder detector (and the elbow one with synergy on), classify
  gcdff_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // decouple the two halves
  gcdff_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // back: feed-forward arithmetic and output register
  gcdff_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire
